// ===== rtl/core/ffa_pkg.sv =====
// Shared types, codes and constants of the first-fit free-list allocator.
`default_nettype none

package ffa_pkg;

    localparam int DEF_MAX_SPANS = 16;
    localparam int DATA_W        = 32;
    localparam int GRAN_W        = 5;
    localparam int CFG_IDX_W     = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAN_LOG2   = 1'b1;

    localparam logic [DATA_W-1:0] RST_REGION_SIZE = 32'd67108864;

    // Request opcodes
    localparam logic OPC_ALLOC = 1'b0;
    localparam logic OPC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_LIST_FULL = 2'd2
    } t_status;

    // One datapath operation per cycle, issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_ALLOC_SHRINK,
        OP_ALLOC_EXACT,
        OP_FREE_EVAL,
        OP_FREE_PRE,
        OP_FREE_POST,
        OP_FREE_BOTH,
        OP_MV_SET_UP,
        OP_MV_RD_DN,
        OP_MV_WR_DN,
        OP_MV_RD_UP,
        OP_MV_WR_UP,
        OP_CNT_DEC,
        OP_INS_WRITE,
        OP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status code;
        logic    idle;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic alloc_bad;
        logic free_skip;
        logic scan_end;
        logic fit;
        logic exact;
        logic stop;
        logic pre;
        logic post;
        logic full;
        logic dn_done;
        logic up_done;
        logic out_busy;
    } t_dp_sts;

    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
    } t_span;

endpackage

`default_nettype wire

// ===== rtl/core/ffa_ifs.sv =====
// Request, response and configuration channel interfaces of the allocator.
`default_nettype none

interface ffa_req_if import ffa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [DATA_W-1:0] req_size;
    logic [DATA_W-1:0] free_offset;

    modport source(output valid, output opcode, output req_size, output free_offset,
                   input ready);
    modport sink(input valid, input opcode, input req_size, input free_offset,
                 output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [DATA_W-1:0] alloc_offset;
    logic [DATA_W-1:0] granted_size;

    modport source(output valid, output status, output alloc_offset, output granted_size,
                   input ready);
    modport sink(input valid, input status, input alloc_offset, input granted_size,
                 output ready);
endinterface

interface ffa_cfg_if import ffa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ffa_ctrl.sv =====
// Sequencer of the allocator: scans, shifts and result handoff.
`default_nettype none

module ffa_ctrl import ffa_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FREE_EVAL,
        S_FREE_ACT,
        S_DN_RD,
        S_DN_WR,
        S_UP_RD,
        S_UP_WR,
        S_RESULT
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;
    t_dp_op  op;

    // Hold state and the pending result code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_code  <= ST_DONE;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // Pick the next state and this cycle's datapath operation
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        op      = OP_NONE;
        unique case (r_state)
            S_INIT: begin
                op      = OP_INIT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    op      = OP_LOAD;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_free ? i_sts.free_skip : i_sts.alloc_bad) begin
                    n_code  = i_sts.is_free ? ST_DONE : ST_NO_FIT;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    if (i_sts.is_free) begin
                        n_state = S_FREE_EVAL;
                    end else begin
                        n_code  = ST_NO_FIT;
                        n_state = S_RESULT;
                    end
                end else begin
                    op      = OP_SCAN_RD;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!i_sts.is_free) begin
                    if (i_sts.fit && i_sts.exact) begin
                        op      = OP_ALLOC_EXACT;
                        n_state = S_DN_RD;
                    end else if (i_sts.fit) begin
                        op      = OP_ALLOC_SHRINK;
                        n_code  = ST_DONE;
                        n_state = S_RESULT;
                    end else begin
                        op      = OP_SCAN_NEXT;
                        n_state = S_SCAN_RD;
                    end
                end else if (i_sts.stop) begin
                    n_state = S_FREE_EVAL;
                end else begin
                    op      = OP_SCAN_NEXT;
                    n_state = S_SCAN_RD;
                end
            end
            S_FREE_EVAL: begin
                op      = OP_FREE_EVAL;
                n_state = S_FREE_ACT;
            end
            S_FREE_ACT: begin
                if (i_sts.pre && i_sts.post) begin
                    op      = OP_FREE_BOTH;
                    n_state = S_DN_RD;
                end else if (i_sts.pre) begin
                    op      = OP_FREE_PRE;
                    n_code  = ST_DONE;
                    n_state = S_RESULT;
                end else if (i_sts.post) begin
                    op      = OP_FREE_POST;
                    n_code  = ST_DONE;
                    n_state = S_RESULT;
                end else if (i_sts.full) begin
                    n_code  = ST_LIST_FULL;
                    n_state = S_RESULT;
                end else begin
                    op      = OP_MV_SET_UP;
                    n_state = S_UP_RD;
                end
            end
            // Close the gap left by a removed span
            S_DN_RD: begin
                if (i_sts.dn_done) begin
                    op      = OP_CNT_DEC;
                    n_code  = ST_DONE;
                    n_state = S_RESULT;
                end else begin
                    op      = OP_MV_RD_DN;
                    n_state = S_DN_WR;
                end
            end
            S_DN_WR: begin
                op      = OP_MV_WR_DN;
                n_state = S_DN_RD;
            end
            // Open a gap for an inserted span
            S_UP_RD: begin
                if (i_sts.up_done) begin
                    op      = OP_INS_WRITE;
                    n_code  = ST_DONE;
                    n_state = S_RESULT;
                end else begin
                    op      = OP_MV_RD_UP;
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                op      = OP_MV_WR_UP;
                n_state = S_UP_RD;
            end
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    op      = OP_RESULT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_cmd.op   = op;
    assign o_cmd.code = r_code;
    assign o_cmd.idle = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/ffa_dpath.sv =====
// Datapath of the allocator: span memory, scan pointers, arithmetic, result register.
`default_nettype none

module ffa_dpath import ffa_pkg::*; #(
    parameter int MAX_SPANS = DEF_MAX_SPANS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic                 i_req_opcode,
    input  wire logic [DATA_W-1:0]    i_req_size,
    input  wire logic [DATA_W-1:0]    i_req_offset,
    input  wire logic                 i_cfg_fire,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [1:0]                o_out_status,
    output logic [DATA_W-1:0]         o_out_offset,
    output logic [DATA_W-1:0]         o_out_granted
);

    localparam int AW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam int CW = $clog2(MAX_SPANS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SPANS);

    // Span list storage, no reset
    t_span r_mem [MAX_SPANS];
    t_span r_rd;

    // Configuration
    logic [DATA_W-1:0] r_region;
    logic [GRAN_W-1:0] r_gran;

    // Request and scan context
    logic              r_opc;
    logic [DATA_W-1:0] r_size;
    logic [DATA_W-1:0] r_off;
    logic [DATA_W:0]   r_rounded;
    logic [DATA_W:0]   r_end;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_mv;
    t_span             r_prev;
    logic              r_pre;
    logic              r_post;
    logic [DATA_W-1:0] r_sum;
    logic [DATA_W-1:0] r_grant_off;

    // Result register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_offset;
    logic [DATA_W-1:0] r_out_granted;

    logic [DATA_W:0]   mask;
    logic [DATA_W:0]   rounded;
    logic [DATA_W:0]   prev_end;
    logic [CW-1:0]     idx_dec;
    logic [CW-1:0]     mv_inc;
    logic [CW-1:0]     mv_dec;
    logic              wr_en;
    logic [CW-1:0]     wr_addr;
    t_span             wr_data;
    logic              rd_en;
    logic [CW-1:0]     rd_addr;
    logic              cfg_region;
    logic              ok_alloc;

    assign mask     = ((DATA_W+1)'(1) << r_gran) - (DATA_W+1)'(1);
    assign rounded  = ({1'b0, i_req_size} + mask) & ~mask;
    assign prev_end = {1'b0, r_prev.start} + {1'b0, r_prev.length};
    assign idx_dec  = r_idx - 1'b1;
    assign mv_inc   = r_mv + 1'b1;
    assign mv_dec   = r_mv - 1'b1;
    assign cfg_region = i_cfg_fire && (i_cfg_index == REG_REGION_SIZE);

    // Steer the single write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '{start: '0, length: r_region};
        if (cfg_region) begin
            wr_en   = 1'b1;
            wr_data = '{start: '0, length: i_cfg_data};
        end else begin
            unique case (i_cmd.op)
                OP_INIT: begin
                    wr_en = 1'b1;
                end
                OP_ALLOC_SHRINK: begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_data = '{start:  r_rd.start + r_rounded[DATA_W-1:0],
                                length: r_rd.length - r_rounded[DATA_W-1:0]};
                end
                OP_FREE_PRE: begin
                    wr_en   = 1'b1;
                    wr_addr = idx_dec;
                    wr_data = '{start: r_prev.start, length: r_sum};
                end
                OP_FREE_BOTH: begin
                    wr_en   = 1'b1;
                    wr_addr = idx_dec;
                    wr_data = '{start: r_prev.start, length: r_sum + r_rd.length};
                end
                OP_FREE_POST: begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_data = '{start: r_off, length: r_rd.length + r_size};
                end
                OP_INS_WRITE: begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_data = '{start: r_off, length: r_size};
                end
                OP_MV_WR_DN, OP_MV_WR_UP: begin
                    wr_en   = 1'b1;
                    wr_addr = r_mv;
                    wr_data = r_rd;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // Steer the read port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        unique case (i_cmd.op)
            OP_SCAN_RD: begin
                rd_en = 1'b1;
            end
            OP_MV_RD_DN: begin
                rd_en   = 1'b1;
                rd_addr = mv_inc;
            end
            OP_MV_RD_UP: begin
                rd_en   = 1'b1;
                rd_addr = mv_dec;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Write the span memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[AW-1:0]] <= wr_data;
        end
    end

    // Read the span memory into a register
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[rd_addr[AW-1:0]];
        end
    end

    // Hold configuration and list length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= RST_REGION_SIZE;
            r_gran   <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_fire) begin
                case (i_cfg_index)
                    REG_REGION_SIZE: r_region <= i_cfg_data;
                    REG_GRAN_LOG2:   r_gran   <= i_cfg_data[GRAN_W-1:0];
                    default:         r_gran   <= r_gran;
                endcase
            end
            if (cfg_region) begin
                r_count <= (i_cfg_data != '0) ? CW'(1) : '0;
            end else if (i_cmd.op == OP_INIT) begin
                r_count <= (r_region != '0) ? CW'(1) : '0;
            end else if (i_cmd.op == OP_INS_WRITE) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.op == OP_CNT_DEC) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Capture the request and advance scan and move pointers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_opc     <= i_req_opcode;
                r_size    <= i_req_size;
                r_off     <= i_req_offset;
                r_rounded <= rounded;
                r_end     <= {1'b0, i_req_offset} + {1'b0, i_req_size};
                r_idx     <= '0;
            end
            OP_SCAN_NEXT: begin
                r_prev <= r_rd;
                r_idx  <= r_idx + 1'b1;
            end
            OP_ALLOC_SHRINK: begin
                r_grant_off <= r_rd.start;
            end
            OP_ALLOC_EXACT: begin
                r_grant_off <= r_rd.start;
                r_mv        <= r_idx;
            end
            OP_FREE_EVAL: begin
                r_pre  <= (r_idx != '0) && (prev_end == {1'b0, r_off});
                r_post <= (r_idx != r_count) && (r_end[DATA_W-1:0] == r_rd.start);
                r_sum  <= r_prev.length + r_size;
            end
            OP_FREE_BOTH: begin
                r_mv <= r_idx;
            end
            OP_MV_SET_UP: begin
                r_mv <= r_count;
            end
            OP_MV_WR_DN: begin
                r_mv <= mv_inc;
            end
            OP_MV_WR_UP: begin
                r_mv <= mv_dec;
            end
            default: begin
                r_mv <= r_mv;
            end
        endcase
    end

    assign ok_alloc = (i_cmd.code == ST_DONE) && (r_opc == OPC_ALLOC);

    // Hold the result until the response side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_RESULT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RESULT) begin
            r_out_status  <= i_cmd.code;
            r_out_offset  <= ok_alloc ? r_grant_off : '0;
            r_out_granted <= ok_alloc ? r_rounded[DATA_W-1:0] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_status  = r_out_status;
    assign o_out_offset  = r_out_offset;
    assign o_out_granted = r_out_granted;

    // Status toward the controller
    assign o_sts.is_free   = (r_opc == OPC_FREE);
    assign o_sts.alloc_bad = (r_size == '0) || r_rounded[DATA_W];
    assign o_sts.free_skip = (r_size == '0) || r_end[DATA_W];
    assign o_sts.scan_end  = (r_idx == r_count);
    assign o_sts.fit       = (r_rd.length >= r_rounded[DATA_W-1:0]);
    assign o_sts.exact     = (r_rd.length == r_rounded[DATA_W-1:0]);
    assign o_sts.stop      = (r_rd.start > r_off);
    assign o_sts.pre       = r_pre;
    assign o_sts.post      = r_post;
    assign o_sts.full      = (r_count == CNT_MAX);
    assign o_sts.dn_done   = (mv_inc >= r_count);
    assign o_sts.up_done   = (r_mv == r_idx);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_free_list_allocator_unit.sv =====
// First-fit free-list allocator with coalescing: top level.
// An allocate loads and checks the request, then reads and compares each span in turn;
// a free also weighs merges after its scan stops or runs off the end of the list.
// Each entry shifted on a removal or insertion takes a read and a write. One request at a time,
// set by the sequential controller; the next is taken while a result waits.
// Reset: the S_INIT state rebuilds the list as [0, region_size).
`default_nettype none

module first_fit_free_list_allocator_unit import ffa_pkg::*; #(
    parameter int MAX_SPANS = DEF_MAX_SPANS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ffa_req_if.sink    i_req,
    ffa_rsp_if.source  o_rsp,
    ffa_cfg_if.sink    i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Give a configuration write the idle slot ahead of a request
    assign i_req.ready = cmd.idle && !i_cfg.valid;
    assign i_cfg.ready = cmd.idle;

    ffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid && !i_cfg.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ffa_dpath #(
        .MAX_SPANS (MAX_SPANS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_opcode  (i_req.opcode),
        .i_req_size    (i_req.req_size),
        .i_req_offset  (i_req.free_offset),
        .i_cfg_fire    (i_cfg.valid && cmd.idle),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_out_status  (o_rsp.status),
        .o_out_offset  (o_rsp.alloc_offset),
        .o_out_granted (o_rsp.granted_size)
    );

endmodule

`default_nettype wire

// ===== verif/ffa_tb_pkg.sv =====
// Scoreboard with a free-list predictor for the first-fit allocator testbench.
package ffa_tb_pkg;
    import ffa_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] size;
    } t_grant;

    class free_list_scoreboard;
        logic [DATA_W-1:0] region_bytes;
        logic [GRAN_W-1:0] gran_log2;
        logic [DATA_W-1:0] span_base[DEF_MAX_SPANS];
        logic [DATA_W-1:0] span_len[DEF_MAX_SPANS];
        int                span_total;
        t_grant            pending_grants[$];
        int                failures;

        function new();
            region_bytes = RST_REGION_SIZE;
            gran_log2    = '0;
            failures     = 0;
            restart_list();
        endfunction

        // Rebuild the list as one span covering the whole region
        function void restart_list();
            for (int k = 0; k < DEF_MAX_SPANS; k++) begin
                span_base[k] = '0;
                span_len[k]  = '0;
            end
            span_len[0] = region_bytes;
            span_total  = (region_bytes != 0) ? 1 : 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            if (idx == REG_REGION_SIZE) begin
                region_bytes = value;
                restart_list();
            end else if (idx == REG_GRAN_LOG2) begin
                gran_log2 = value[GRAN_W-1:0];
            end
        endfunction

        // Close the gap left by entry idx
        function void drop_span(int idx);
            for (int k = idx; k + 1 < span_total; k++) begin
                span_base[k] = span_base[k + 1];
                span_len[k]  = span_len[k + 1];
            end
            if (span_total > 0)
                span_total--;
        endfunction

        // First fit: take the lowest span long enough for the rounded size
        function t_grant predict_allocate(logic [DATA_W-1:0] size);
            logic [63:0] mask;
            logic [63:0] rounded;
            t_grant      grant;
            grant.status = ST_NO_FIT;
            grant.offset = '0;
            grant.size   = '0;
            mask    = (64'd1 << gran_log2) - 64'd1;
            rounded = ({32'd0, size} + mask) & ~mask;
            if (size == 0 || rounded > 64'hFFFF_FFFF)
                return grant;
            for (int k = 0; k < span_total; k++) begin
                if ({32'd0, span_len[k]} >= rounded) begin
                    grant.status = ST_DONE;
                    grant.offset = span_base[k];
                    grant.size   = rounded[DATA_W-1:0];
                    if ({32'd0, span_len[k]} == rounded) begin
                        drop_span(k);
                    end else begin
                        span_len[k]  -= rounded[DATA_W-1:0];
                        span_base[k] += rounded[DATA_W-1:0];
                    end
                    return grant;
                end
            end
            return grant;
        endfunction

        // Return a span: merge on exact contact, else insert in offset order
        function t_status predict_free(logic [DATA_W-1:0] size, logic [DATA_W-1:0] offset);
            logic [63:0] span_end;
            logic [63:0] below_end;
            int          n;
            int          i;
            logic        pre;
            logic        post;
            span_end = {32'd0, offset} + {32'd0, size};
            if (size == 0 || span_end > 64'hFFFF_FFFF)
                return ST_DONE;
            n = span_total;
            i = 0;
            while (i < n && span_base[i] <= offset)
                i++;
            pre  = 1'b0;
            post = 1'b0;
            if (i > 0) begin
                below_end = {32'd0, span_base[i - 1]} + {32'd0, span_len[i - 1]};
                pre = (below_end == {32'd0, offset});
            end
            if (i < n)
                post = (span_end == {32'd0, span_base[i]});
            if (pre && post) begin
                span_len[i - 1] = span_base[i] + span_len[i] - span_base[i - 1];
                drop_span(i);
            end else if (pre) begin
                span_len[i - 1] = span_end[DATA_W-1:0] - span_base[i - 1];
            end else if (post) begin
                span_len[i]  += size;
                span_base[i]  = offset;
            end else begin
                if (n >= DEF_MAX_SPANS)
                    return ST_LIST_FULL;
                for (int k = n; k > i; k--) begin
                    span_base[k] = span_base[k - 1];
                    span_len[k]  = span_len[k - 1];
                end
                span_base[i] = offset;
                span_len[i]  = size;
                span_total   = n + 1;
            end
            return ST_DONE;
        endfunction

        // Predict the response to an accepted request and queue it
        function t_grant note_request(logic op, logic [DATA_W-1:0] size,
                                      logic [DATA_W-1:0] offset);
            t_grant grant;
            if (op == OPC_ALLOC) begin
                grant = predict_allocate(size);
            end else begin
                grant.status = predict_free(size, offset);
                grant.offset = '0;
                grant.size   = '0;
            end
            pending_grants.push_back(grant);
            return grant;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        // Compare an accepted response with the oldest prediction
        function void check_response(logic [1:0] status, logic [DATA_W-1:0] offset,
                                     logic [DATA_W-1:0] size);
            t_grant want;
            if (pending_grants.size() == 0) begin
                flag($sformatf("unexpected response: status %0d offset %h size %h",
                               status, offset, size));
                return;
            end
            want = pending_grants.pop_front();
            if (want.status != status || want.offset !== offset || want.size !== size)
                flag($sformatf({"response mismatch: expected status %0d offset %h size %h,",
                                " got status %0d offset %h size %h"},
                               want.status, want.offset, want.size, status, offset, size));
        endfunction
    endclass

endpackage

// ===== verif/testbench.sv =====
// Top-level testbench of the first-fit free-list allocator.
module testbench;
    import ffa_pkg::*;
    import ffa_tb_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 100;

    logic i_clk;
    logic i_rst_n;

    ffa_req_if req_ch();
    ffa_rsp_if rsp_ch();
    ffa_cfg_if cfg_ch();

    free_list_scoreboard sb = new();

    logic              steady      = 1'b0;
    logic              rsp_holdoff = 1'b0;
    int                cycle_count = 0;
    t_grant            last_grant;
    logic [DATA_W-1:0] held_base[$];
    logic [DATA_W-1:0] held_len[$];

    first_fit_free_list_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a run that hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Drive response ready: random idling, one long hold-off on demand
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_holdoff) begin
                rsp_holdoff = 1'b0;
                rsp_ch.ready <= 1'b0;
                for (int n = 0; n < HOLDOFF_CYCLES; n++)
                    @(negedge i_clk);
            end
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 34);
        end
    end

    // Check every accepted response
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.alloc_offset, rsp_ch.granted_size);
    end

    // Offer one request, hold it until accepted; valid stays high on return
    task automatic send_request(input logic op, input logic [DATA_W-1:0] size,
                                input logic [DATA_W-1:0] offset);
        while (!steady && $urandom_range(0, 99) < 34) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.req_size    <= size;
        req_ch.free_offset <= offset;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        last_grant = sb.note_request(op, size, offset);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted response has arrived
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(negedge i_clk);
        while (sb.pending_grants.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        sb.set_register(idx, value);
        @(negedge i_clk);
    endtask

    // Set both registers on an idle block; the list restarts
    task automatic configure(input logic [DATA_W-1:0] region, input logic [GRAN_W-1:0] gran);
        drain();
        write_register(REG_REGION_SIZE, region);
        write_register(REG_GRAN_LOG2, DATA_W'(gran));
        cfg_ch.valid <= 1'b0;
        held_base.delete();
        held_len.delete();
    endtask

    task automatic take(input logic [DATA_W-1:0] size);
        send_request(OPC_ALLOC, size, $urandom());
        if (last_grant.status == ST_DONE) begin
            held_base.push_back(last_grant.offset);
            held_len.push_back(last_grant.size);
        end
    endtask

    task automatic give_back(input int idx);
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] len;
        base = held_base[idx];
        len  = held_len[idx];
        held_base.delete(idx);
        held_len.delete(idx);
        send_request(OPC_FREE, len, base);
    endtask

    // Mostly well-formed traffic on live blocks, with some noise
    task automatic run_mix(input int count, input logic [DATA_W-1:0] size_max);
        int                r;
        int                idx;
        logic [DATA_W-1:0] cut;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45 || (held_base.size() == 0 && r < 88)) begin
                take($urandom_range(1, size_max));
            end else if (r < 80) begin
                give_back($urandom_range(0, held_base.size() - 1));
            end else if (r < 88) begin
                // release the top or bottom part of a live block
                idx = $urandom_range(0, held_base.size() - 1);
                cut = $urandom_range(1, held_len[idx]);
                if ($urandom_range(0, 1)) begin
                    send_request(OPC_FREE, cut, held_base[idx] + held_len[idx] - cut);
                end else begin
                    send_request(OPC_FREE, cut, held_base[idx]);
                    held_base[idx] += cut;
                end
                held_len[idx] -= cut;
                if (held_len[idx] == 0) begin
                    held_base.delete(idx);
                    held_len.delete(idx);
                end
            end else begin
                send_request(1'($urandom_range(0, 1)),
                             ($urandom_range(0, 3) == 0) ? '0 : DATA_W'($urandom()),
                             $urandom());
            end
        end
    endtask

    // Allocate a run of blocks, free every other one, then the rest
    task automatic run_fragment(input int count, input logic [DATA_W-1:0] size_max);
        for (int n = 0; n < count; n++)
            take($urandom_range(1, size_max));
        for (int k = held_base.size() - 1; k >= 0; k -= 2)
            give_back(k);
        while (held_base.size() != 0)
            give_back($urandom_range(0, held_base.size() - 1));
    endtask

    // Free disjoint spans in random order into an empty list
    task automatic seed_spans(input int count, input logic [DATA_W-1:0] pitch);
        int slots[$];
        int idx;
        for (int k = 0; k < count; k++)
            slots.push_back(k);
        while (slots.size() != 0) begin
            idx = $urandom_range(0, slots.size() - 1);
            send_request(OPC_FREE, pitch >> 1, slots[idx] * pitch);
            slots.delete(idx);
        end
    endtask

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OPC_ALLOC;
        req_ch.req_size    = '0;
        req_ch.free_offset = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_REGION_SIZE;
        cfg_ch.data        = '0;
        i_rst_n            = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero sizes, huge request, merges, exact fit, empty list
        send_request(OPC_ALLOC, 32'd0, 32'd0);
        send_request(OPC_FREE, 32'd0, 32'hFFFF_FFFF);
        send_request(OPC_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(OPC_ALLOC, 32'd100, 32'd0);
        send_request(OPC_ALLOC, 32'd200, 32'd0);
        send_request(OPC_FREE, 32'd100, 32'd0);
        send_request(OPC_FREE, 32'd200, 32'd100);
        send_request(OPC_ALLOC, RST_REGION_SIZE, 32'd0);
        send_request(OPC_ALLOC, 32'd1, 32'd0);
        send_request(OPC_FREE, RST_REGION_SIZE, 32'd0);
        send_request(OPC_FREE, 32'h20, 32'hFFFF_FFF0);
        send_request(OPC_FREE, 32'd16, RST_REGION_SIZE);
        send_request(OPC_FREE, 32'd16, RST_REGION_SIZE + 32'h20);
        send_request(OPC_FREE, 32'd16, RST_REGION_SIZE + 32'h10);

        // Directed: widest granularity, rounding past 32 bits
        configure(32'hFFFF_FFFF, 5'd31);
        send_request(OPC_ALLOC, 32'h8000_0001, 32'd0);
        send_request(OPC_ALLOC, 32'd1, 32'd0);
        send_request(OPC_ALLOC, 32'd1, 32'd0);
        send_request(OPC_FREE, 32'h8000_0000, 32'd0);

        // Directed: zero region, span ending at the top of the address space
        configure(32'd0, 5'd0);
        send_request(OPC_ALLOC, 32'd5, 32'd0);
        send_request(OPC_FREE, 32'd8, 32'hFFFF_FFF7);
        send_request(OPC_FREE, 32'd1, 32'hFFFF_FFFF);

        // Small region, coarse granularity, no idling
        configure(32'd4096, 5'd4);
        steady = 1'b1;
        run_mix(150, 32'd300);
        drain();
        steady = 1'b0;

        // Full region, 64K granules; hold responses off to fill the block
        configure(32'hFFFF_FFFF, 5'd16);
        rsp_holdoff = 1'b1;
        run_fragment(36, 32'h0002_0000);
        run_mix(120, 32'h0010_0000);

        // Single-byte region
        configure(32'd1, 5'd0);
        run_mix(60, 32'd2);

        // Empty region filled by frees until the list is full
        configure(32'd0, 5'd3);
        seed_spans(20, 32'd64);
        run_mix(100, 32'd40);

        // Mid-size region, pause the sender until all responses are in
        configure(32'd65536, 5'($urandom_range(0, 6)));
        run_fragment(36, 32'd1000);
        drain();
        run_mix(120, 32'd5000);

        // Widest granularity on the full region
        configure(32'hFFFF_FFFF, 5'd31);
        run_mix(40, 32'hFFFF_FFFF);

        // Random region and granularity
        configure($urandom_range(1, 32'h0010_0000), 5'($urandom_range(0, 31)));
        run_mix(130, 32'd4096);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending_grants.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
